/* sv/assert_macros.svh */
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, switched off while reset is held
`define ASSERT_SYNC(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that also holds through reset
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* sv/pli_pkg.sv */
// types and constants of the piecewise linear interpolator
package pli_pkg;

    // function codes of an input word
    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_EVAL  = 1'b1;

    // fixed point format
    localparam int FRAC_BITS = 16;

    // shortest usable segment span: 1e-6 in real units, rounded up to raw counts
    localparam longint TINY_DIV   = 1000000;
    localparam longint SPAN_MIN_L = ((longint'(1) << FRAC_BITS) + TINY_DIV - 1) / TINY_DIV;
    localparam logic signed [32:0] SPAN_MIN = 33'(SPAN_MIN_L);

    // result range
    localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

    // divider widths: 33 x 33 bit product over a 32 bit span
    localparam int DVD_W = 66;
    localparam int DVS_W = 32;
    localparam int QUO_W = 35;

    // table entry: parameter in the upper half, value in the lower half
    localparam int ENTRY_W = 64;

    typedef struct packed {
        logic             start;
        logic [DVD_W-1:0] dividend;
        logic [DVS_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [QUO_W-1:0] quot;
        logic             ovf;
    } t_div_rsp;

endpackage

/* sv/pli_div.sv */
// radix-4 restoring divider, two quotient bits per cycle
module pli_div import pli_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    localparam int STEPS = DVD_W / 2;
    localparam int CNT_W = $clog2(STEPS + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DVD_W-1:0] r_dvd;
    logic [DVS_W-1:0] r_dvs;
    logic [DVS_W-1:0] r_rem;
    logic [QUO_W-1:0] r_quot;
    logic             r_ovf;

    logic [DVS_W:0]   sh1;
    logic [DVS_W:0]   sh2;
    logic [DVS_W:0]   rem1;
    logic [DVS_W:0]   rem2;
    logic             ge1;
    logic             ge2;

    // two dependent subtract and compare steps
    always_comb begin
        sh1  = {r_rem, r_dvd[DVD_W-1]};
        ge1  = sh1 >= {1'b0, r_dvs};
        rem1 = ge1 ? (sh1 - {1'b0, r_dvs}) : sh1;
        sh2  = {rem1[DVS_W-1:0], r_dvd[DVD_W-2]};
        ge2  = sh2 >= {1'b0, r_dvs};
        rem2 = ge2 ? (sh2 - {1'b0, r_dvs}) : sh2;
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(STEPS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath; quotient bits above the kept width only mark overflow
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_dvd  <= i_req.dividend;
            r_dvs  <= i_req.divisor;
            r_rem  <= '0;
            r_quot <= '0;
            r_ovf  <= 1'b0;
        end else if (r_busy) begin
            r_dvd  <= {r_dvd[DVD_W-3:0], 2'b00};
            r_rem  <= rem2[DVS_W-1:0];
            r_quot <= {r_quot[QUO_W-3:0], ge1, ge2};
            r_ovf  <= r_ovf | r_quot[QUO_W-1] | r_quot[QUO_W-2];
        end
    end

    always_comb begin
        o_rsp.done = r_done;
        o_rsp.quot = r_quot;
        o_rsp.ovf  = r_ovf;
    end

endmodule

/* sv/piecewise_linear_interpolator.sv */
// Piecewise linear interpolator: breakpoint table, binary search, serial divide.
// Input channel (i_in_valid / o_in_stall): a word with i_func write stores
// i_point_param and i_point_value in slot i_point_index and gives
// no result. A word with i_func evaluate interpolates at i_query_param and
// gives one result word on the output channel (o_out_valid / i_out_stall).
// i_cfg_we loads i_cfg_data as the number of breakpoints in use.
// An evaluate word runs a binary search over the table, each step a registered
// table read and a compare, then fetches the two segment end points and does
// a 33 x 33 multiply and a radix-4 divide. Empty and single-point tables
// skip the search and the arithmetic.
// The block holds one evaluate word at a time; o_in_stall is high from the
// cycle after acceptance until the result moves into the output register.
// The output register holds a finished result while the receiver stalls, and
// the block takes the next word meanwhile; a second result waits for it.
// Reset clears the control state and the point count; the table is not
// cleared and reads of unwritten slots return arbitrary data.
module piecewise_linear_interpolator import pli_pkg::*; #(
    parameter int MAX_POINTS = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_func,
    input  logic [5:0]         i_point_index,
    input  logic signed [31:0] i_point_param,
    input  logic signed [31:0] i_point_value,
    input  logic signed [31:0] i_query_param,
    input  logic               i_cfg_we,
    input  logic [6:0]         i_cfg_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [31:0] o_result_value,
    output logic [5:0]         o_segment_start,
    output logic               o_saturated
);

    localparam int AW  = $clog2(MAX_POINTS);
    localparam int CW  = $clog2(MAX_POINTS + 1);
    localparam int NW  = (CW > 7) ? CW : 7;
    localparam int XW  = AW + 6;

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_SRCH_RD  = 4'd1;
    localparam logic [3:0] S_SRCH_CMP = 4'd2;
    localparam logic [3:0] S_FETCH0   = 4'd3;
    localparam logic [3:0] S_FETCH1   = 4'd4;
    localparam logic [3:0] S_DIFF     = 4'd5;
    localparam logic [3:0] S_ABS      = 4'd6;
    localparam logic [3:0] S_MUL      = 4'd7;
    localparam logic [3:0] S_DIV      = 4'd8;
    localparam logic [3:0] S_FINISH   = 4'd9;
    localparam logic [3:0] S_DONE     = 4'd10;

    localparam logic signed [36:0] TOT_MAX = 37'(Q_MAX);
    localparam logic signed [36:0] TOT_MIN = 37'(Q_MIN);

    logic [3:0]               r_state;
    logic [3:0]               n_state;
    logic [6:0]               r_cfg_count;

    logic [ENTRY_W-1:0]       mem [MAX_POINTS];
    logic [ENTRY_W-1:0]       r_rd_data;
    logic [AW-1:0]            rd_addr;

    logic signed [31:0]       r_q;
    logic [AW-1:0]            r_left;
    logic [AW-1:0]            r_right;
    logic [AW-1:0]            r_mid;
    logic [AW-1:0]            n_left;
    logic [AW-1:0]            n_right;
    logic [AW-1:0]            n_mid;
    logic [AW:0]              mid_sum;
    logic                     r_single;

    logic signed [31:0]       r_p0;
    logic signed [31:0]       r_v0;
    logic signed [32:0]       r_span;
    logic signed [32:0]       r_dq;
    logic signed [32:0]       r_dv;
    logic [32:0]              r_mag_dq;
    logic [32:0]              r_mag_dv;
    logic                     r_neg;
    logic                     r_short;
    logic [DVD_W-1:0]         r_prod;
    logic                     r_div_start;
    t_div_req                 div_req;
    t_div_rsp                 div_rsp;

    logic signed [31:0]       rd_p;
    logic signed [31:0]       rd_v;
    logic                     in_acc;
    logic [NW-1:0]            cnt_ext;
    logic [NW-1:0]            n_pts;
    logic [NW-1:0]            last_pt;
    logic [AW-1:0]            last_idx;
    logic [XW-1:0]            idx_ext;
    logic                     wr_ok;
    logic [XW-1:0]            seg_ext;

    logic signed [36:0]       v0_ext;
    logic signed [36:0]       mag_ext;
    logic signed [36:0]       total;
    logic signed [31:0]       fin_value;
    logic                     fin_sat;

    logic signed [31:0]       r_res_value;
    logic                     r_res_sat;
    logic                     r_out_valid;
    logic signed [31:0]       r_out_value;
    logic [5:0]               r_out_seg;
    logic                     r_out_sat;

    assign in_acc     = i_in_valid && (r_state == S_IDLE);
    assign o_in_stall = (r_state != S_IDLE);

    // points in use, limited to the table depth
    assign cnt_ext  = NW'(r_cfg_count);
    assign n_pts    = (cnt_ext > NW'(MAX_POINTS)) ? NW'(MAX_POINTS) : cnt_ext;
    assign last_pt  = n_pts - NW'(1);
    assign last_idx = last_pt[AW-1:0];

    // write slot range check
    assign idx_ext = XW'(i_point_index);
    assign wr_ok   = idx_ext < XW'(MAX_POINTS);
    assign seg_ext = XW'(r_left);

    assign rd_p = r_rd_data[63:32];
    assign rd_v = r_rd_data[31:0];

    // config register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_count <= '0;
        end else if (i_cfg_we) begin
            r_cfg_count <= i_cfg_data;
        end
    end

    // breakpoint table, one write and one registered read port
    always_comb begin
        case (r_state)
            S_SRCH_RD: rd_addr = r_mid;
            S_FETCH0:  rd_addr = r_left;
            S_FETCH1:  rd_addr = r_left + AW'(1);
            default:   rd_addr = r_left;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && (i_func == FUNC_WRITE) && wr_ok) begin
            mem[idx_ext[AW-1:0]] <= {i_point_param, i_point_value};
        end
        r_rd_data <= mem[rd_addr];
    end

    // one binary search step
    always_comb begin
        if (r_q <= rd_p) begin
            n_left  = r_left;
            n_right = r_mid;
        end else begin
            n_left  = r_mid;
            n_right = r_right;
        end
        mid_sum = {1'b0, n_left} + {1'b0, n_right};
        n_mid   = mid_sum[AW:1];
    end

    // final sum and saturation
    always_comb begin
        v0_ext  = 37'(r_v0);
        mag_ext = $signed({2'b00, div_rsp.quot});
        total   = r_neg ? (v0_ext - mag_ext) : (v0_ext + mag_ext);
        if (div_rsp.ovf) begin
            fin_sat   = 1'b1;
            fin_value = r_neg ? Q_MIN : Q_MAX;
        end else if (total > TOT_MAX) begin
            fin_sat   = 1'b1;
            fin_value = Q_MAX;
        end else if (total < TOT_MIN) begin
            fin_sat   = 1'b1;
            fin_value = Q_MIN;
        end else begin
            fin_sat   = 1'b0;
            fin_value = total[31:0];
        end
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc && (i_func == FUNC_EVAL)) begin
                    if (n_pts == '0) begin
                        n_state = S_DONE;
                    end else if ((last_idx >> 1) == '0) begin
                        n_state = S_FETCH0;
                    end else begin
                        n_state = S_SRCH_RD;
                    end
                end
            end
            S_SRCH_RD:  n_state = S_SRCH_CMP;
            S_SRCH_CMP: n_state = (n_mid == n_left) ? S_FETCH0 : S_SRCH_RD;
            S_FETCH0:   n_state = S_FETCH1;
            S_FETCH1:   n_state = r_single ? S_DONE : S_DIFF;
            S_DIFF:     n_state = S_ABS;
            S_ABS:      n_state = S_MUL;
            S_MUL:      n_state = r_short ? S_DONE : S_DIV;
            S_DIV:      n_state = div_rsp.done ? S_FINISH : S_DIV;
            S_FINISH:   n_state = S_DONE;
            S_DONE:     n_state = (!r_out_valid || !i_out_stall) ? S_IDLE : S_DONE;
            default:    n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_div_start <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_div_start <= (r_state == S_MUL) && !r_short;
        end
    end

    // search and arithmetic datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_q         <= i_query_param;
                r_left      <= '0;
                r_right     <= last_idx;
                r_mid       <= last_idx >> 1;
                r_single    <= (n_pts == NW'(1));
                r_res_value <= '0;
                r_res_sat   <= 1'b0;
            end
            S_SRCH_CMP: begin
                r_left  <= n_left;
                r_right <= n_right;
                r_mid   <= n_mid;
            end
            S_FETCH1: begin
                r_p0        <= rd_p;
                r_v0        <= rd_v;
                r_res_value <= rd_v;
                r_res_sat   <= 1'b0;
            end
            S_DIFF: begin
                r_span <= {rd_p[31], rd_p} - {r_p0[31], r_p0};
                r_dq   <= {r_q[31], r_q} - {r_p0[31], r_p0};
                r_dv   <= {rd_v[31], rd_v} - {r_v0[31], r_v0};
            end
            S_ABS: begin
                r_short  <= r_span < SPAN_MIN;
                r_neg    <= r_dq[32] != r_dv[32];
                r_mag_dq <= r_dq[32] ? 33'(-r_dq) : 33'(r_dq);
                r_mag_dv <= r_dv[32] ? 33'(-r_dv) : 33'(r_dv);
            end
            S_MUL: begin
                r_prod      <= r_mag_dq * r_mag_dv;
                r_res_value <= r_v0;
                r_res_sat   <= 1'b0;
            end
            S_FINISH: begin
                r_res_value <= fin_value;
                r_res_sat   <= fin_sat;
            end
            default: begin
                r_q <= r_q;
            end
        endcase
    end

    // serial divider
    always_comb begin
        div_req.start    = r_div_start;
        div_req.dividend = r_prod;
        div_req.divisor  = r_span[31:0];
    end

    pli_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == S_DONE) && (!r_out_valid || !i_out_stall)) begin
            r_out_valid <= 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_DONE) && (!r_out_valid || !i_out_stall)) begin
            r_out_value <= r_res_value;
            r_out_seg   <= seg_ext[5:0];
            r_out_sat   <= r_res_sat;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_result_value  = r_out_value;
    assign o_segment_start = r_out_seg;
    assign o_saturated     = r_out_sat;

endmodule

/* sv/pli_chk.sv */
// port checker for the piecewise linear interpolator, with its bind
`include "assert_macros.svh"

module pli_chk import pli_pkg::*; (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input logic               i_func,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input logic signed [31:0] o_result_value,
    input logic [5:0]         o_segment_start,
    input logic               o_saturated
);

    // a stalled result word stays offered
    `ASSERT_SYNC(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall |=> o_out_valid, "output word dropped under stall")

    // a stalled result word does not change
    `ASSERT_SYNC(a_out_stable, i_clk, i_rst_n, o_out_valid && i_out_stall |=> $stable(o_result_value) && $stable(o_segment_start) && $stable(o_saturated), "output word changed under stall")

    // an evaluate word keeps the block busy for the following cycle
    `ASSERT_SYNC(a_eval_busy, i_clk, i_rst_n, i_in_valid && !o_in_stall && i_func == FUNC_EVAL |=> o_in_stall, "evaluate word did not occupy the block")

    // a clipped result is one of the range limits
    `ASSERT_SYNC(a_sat_limit, i_clk, i_rst_n, o_out_valid && o_saturated |-> o_result_value == Q_MAX || o_result_value == Q_MIN, "saturated result not at a range limit")

    // reset leaves the block ready and empty
    `ASSERT_ALWAYS(a_reset_idle, i_clk, !i_rst_n |=> !o_out_valid && !o_in_stall, "block not idle after reset")

endmodule

bind piecewise_linear_interpolator pli_chk u_pli_chk (.*);
